// ===== hw/rtl/fsbm_pkg.sv =====
package fsbm_pkg;

    // Command codes of an input request.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Register indexes.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BSIZE  = 2'd2;
    localparam logic [1:0] REG_RANGE  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND,
        ST_PIX,
        ST_DRAIN,
        ST_DONE,
        ST_OUT
    } fsbm_state_t;

endpackage

// ===== hw/rtl/fsbm_ram.sv =====
module fsbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/full_search_block_matching_top.sv =====
// Full-search block matching over two luma frames held in on-chip RAM.
// Input stream s_axis: each request either loads one pixel into the
// reference or current frame (cmd = 0) or searches one block (cmd = 1).
// A load produces no result. A search scans every
// displacement from -range to +range, vertical outer and horizontal inner,
// skips candidates that leave the frame and returns the vector with the
// first strictly smallest sum of absolute differences on m_axis.
// The two frame RAMs have one read port each, so one pixel pair is
// compared per cycle; a candidate that leaves the frame reads no pixels.
// A zero block size or a block not wholly inside the frame returns status 1 in the next cycle.
// The block works on one request at a time; s_tready is low during a
// search and while a result waits in the output register, which holds
// until m_tready is high. Reset restores the register defaults and clears
// control state; frame contents stay undefined until written.
// Registers are written through the APB port at byte address 4*i.
module full_search_block_matching_top #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int MAX_BLOCK  = 16,
    parameter int MAX_RANGE  = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata fields from bit 0: frame_select, pixel_x[7], pixel_y[7],
    // pixel_value[8], block_col[7], block_row[7], zero pad to 40 bits.
    input  logic [39:0] s_tdata,
    // s_tuser fields: cmd.
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata fields from bit 0: mv_dx[5], mv_dy[5], best_sad[16], pad.
    output logic [31:0] m_tdata,
    // m_tuser fields: status.
    output logic        m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fsbm_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int CW = 14;   // signed coordinate width, covers 2*4096
    localparam int PW = $clog2(MAX_BLOCK);

    // Configuration registers.
    logic [7:0] frame_width_reg;
    logic [7:0] frame_height_reg;
    logic [4:0] block_size_reg;
    logic [3:0] search_range_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 8'd128;
            frame_height_reg <= 8'd128;
            block_size_reg   <= 5'd8;
            search_range_reg <= 4'd7;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                REG_WIDTH:  frame_width_reg  <= pwdata[7:0];
                REG_HEIGHT: frame_height_reg <= pwdata[7:0];
                REG_BSIZE:  block_size_reg   <= pwdata[4:0];
                REG_RANGE:  search_range_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_WIDTH:  prdata[7:0] = frame_width_reg;
            REG_HEIGHT: prdata[7:0] = frame_height_reg;
            REG_BSIZE:  prdata[4:0] = block_size_reg;
            REG_RANGE:  prdata[3:0] = search_range_reg;
            default: ;
        endcase
    end

    // Effective, saturated configuration.
    logic signed [CW-1:0] w_eff, h_eff, bs_eff, r_eff;
    assign w_eff  = (32'(frame_width_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH)
                                                       : CW'(frame_width_reg);
    assign h_eff  = (32'(frame_height_reg) > MAX_HEIGHT) ? CW'(MAX_HEIGHT)
                                                         : CW'(frame_height_reg);
    assign bs_eff = (32'(block_size_reg) > MAX_BLOCK) ? CW'(MAX_BLOCK)
                                                      : CW'(block_size_reg);
    assign r_eff  = (32'(search_range_reg) > MAX_RANGE) ? CW'(MAX_RANGE)
                                                        : CW'(search_range_reg);

    // Input fields.
    logic       in_sel;
    logic [6:0] in_px, in_py, in_bcol, in_brow;
    logic [7:0] in_val;
    assign in_sel  = s_tdata[0];
    assign in_px   = s_tdata[7:1];
    assign in_py   = s_tdata[14:8];
    assign in_val  = s_tdata[22:15];
    assign in_bcol = s_tdata[29:23];
    assign in_brow = s_tdata[36:30];

    fsbm_state_t state_reg, state_next;

    logic s_fire;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Loads write straight into the selected frame RAM.
    logic load_ok, ref_we, cur_we;
    logic [AW-1:0] load_addr;
    assign load_ok   = (32'(in_px) < MAX_WIDTH) && (32'(in_py) < MAX_HEIGHT);
    assign load_addr = {YW'(in_py), XW'(in_px)};
    assign ref_we    = s_fire && (s_tuser == CMD_LOAD) && load_ok && !in_sel;
    assign cur_we    = s_fire && (s_tuser == CMD_LOAD) && load_ok && in_sel;

    // Search state.
    logic signed [CW-1:0] cx_reg, cy_reg, dx_reg, dy_reg;
    logic [PW-1:0]        pi_reg, pj_reg;
    logic [23:0]          sum_reg, best_reg;
    logic signed [CW-1:0] bdx_reg, bdy_reg;
    logic                 acc_en_reg, last_reg;
    logic                 st_reg;

    logic signed [CW-1:0] cx_in, cy_in;
    assign cx_in = CW'(32'(in_bcol) * 32'(bs_eff));
    assign cy_in = CW'(32'(in_brow) * 32'(bs_eff));

    // Candidate origin and in-frame check.
    logic signed [CW-1:0] rx, ry;
    logic                 cand_in;
    assign rx = cx_reg + dx_reg;
    assign ry = cy_reg + dy_reg;
    assign cand_in = (rx >= 0) && (ry >= 0) && (rx + bs_eff <= w_eff)
                     && (ry + bs_eff <= h_eff);

    logic last_i, last_j, last_dx, last_dy;
    assign last_i  = (CW'(pi_reg) == bs_eff - 1);
    assign last_j  = (CW'(pj_reg) == bs_eff - 1);
    assign last_dx = (dx_reg == r_eff);
    assign last_dy = (dy_reg == r_eff);

    // Read addresses for the pixel pair.
    logic signed [CW-1:0] rxa, rya, cxa, cya;
    logic [AW-1:0] ref_raddr, cur_raddr;
    assign rxa = rx + CW'(pi_reg);
    assign rya = ry + CW'(pj_reg);
    assign cxa = cx_reg + CW'(pi_reg);
    assign cya = cy_reg + CW'(pj_reg);
    assign ref_raddr = {rya[YW-1:0], rxa[XW-1:0]};
    assign cur_raddr = {cya[YW-1:0], cxa[XW-1:0]};

    logic [7:0] ref_rdata, cur_rdata;

    fsbm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_ref_ram (
        .aclk(aclk), .we(ref_we), .waddr(load_addr), .wdata(in_val),
        .raddr(ref_raddr), .rdata(ref_rdata)
    );

    fsbm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_cur_ram (
        .aclk(aclk), .we(cur_we), .waddr(load_addr), .wdata(in_val),
        .raddr(cur_raddr), .rdata(cur_rdata)
    );

    logic [7:0] absd;
    assign absd = (ref_rdata > cur_rdata) ? ref_rdata - cur_rdata
                                          : cur_rdata - ref_rdata;

    logic [23:0] sum_full;
    assign sum_full = sum_reg + 24'(absd);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tuser == CMD_SEARCH) begin
                    if (bs_eff == 0 || cx_in + bs_eff > w_eff
                        || cy_in + bs_eff > h_eff) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_CAND;
                    end
                end
            end
            ST_CAND: begin
                if (acc_en_reg && last_reg) begin
                    state_next = ST_CAND;
                end else if (cand_in) begin
                    state_next = ST_PIX;
                end else if (last_dx && last_dy) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_PIX: begin
                if (last_i && last_j) begin
                    state_next = (last_dx && last_dy) ? ST_DRAIN : ST_CAND;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:  state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Candidate and pixel counters, accumulator and best tracking.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
            last_reg   <= 1'b0;
        end else begin
            acc_en_reg <= (state_reg == ST_PIX);
            last_reg   <= (state_reg == ST_PIX) && last_i && last_j;
        end

        // Accumulate the difference of the pair read last cycle.
        if (acc_en_reg) begin
            if (last_reg) begin
                sum_reg <= '0;
                if (sum_full < best_reg) begin
                    best_reg <= sum_full;
                    bdx_reg  <= dx_reg;
                    bdy_reg  <= dy_reg;
                end
            end else begin
                sum_reg <= sum_full;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                cx_reg   <= cx_in;
                cy_reg   <= cy_in;
                dx_reg   <= -r_eff;
                dy_reg   <= -r_eff;
                pi_reg   <= '0;
                pj_reg   <= '0;
                sum_reg  <= '0;
                best_reg <= '1;
                bdx_reg  <= '0;
                bdy_reg  <= '0;
                st_reg   <= 1'b1;
            end
            ST_CAND: begin
                st_reg <= 1'b0;
                if (!cand_in) begin
                    if (last_dx) begin
                        dx_reg <= -r_eff;
                        dy_reg <= dy_reg + CW'(1);
                    end else begin
                        dx_reg <= dx_reg + CW'(1);
                    end
                end
            end
            ST_PIX: begin
                if (last_i) begin
                    pi_reg <= '0;
                    if (last_j) begin
                        pj_reg <= '0;
                    end else begin
                        pj_reg <= pj_reg + 1'b1;
                    end
                end else begin
                    pi_reg <= pi_reg + 1'b1;
                end
            end
            default: ;
        endcase

        // For an in-frame candidate the displacement moves only once the final pair is summed.
        if (last_reg && acc_en_reg && state_reg != ST_DONE) begin
            if (dx_reg == r_eff) begin
                if (dy_reg != r_eff) begin
                    dx_reg <= -r_eff;
                    dy_reg <= dy_reg + CW'(1);
                end
            end else begin
                dx_reg <= dx_reg + CW'(1);
            end
        end
    end

    // PIX returns to CAND with dx unchanged; CAND holds while
    // the accumulator closes the candidate and dx advances, so the next
    // in-frame check sees the new displacement.
    // Output register.
    logic [15:0] sad_sat;
    assign sad_sat = (best_reg > 24'hFFFF) ? 16'hFFFF : best_reg[15:0];

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tuser  = st_reg;
    assign m_tdata  = st_reg ? 32'd0
                             : {6'd0, sad_sat, bdy_reg[4:0], bdx_reg[4:0]};

endmodule

// ===== hw/rtl/fsbm_checker.sv =====
module fsbm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // A result waiting on a stall keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // No new request is taken while a result is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // An error result carries a zero vector and sum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("error result with payload");

endmodule

bind full_search_block_matching_top fsbm_checker u_fsbm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import fsbm_pkg::*;

    typedef struct {
        logic       cmd;
        logic       frame_sel;
        logic [6:0] px;
        logic [6:0] py;
        logic [7:0] pval;
        logic [6:0] bcol;
        logic [6:0] brow;
    } request_t;

    typedef struct {
        logic [4:0]  dx;
        logic [4:0]  dy;
        logic [15:0] sad;
        logic        status;
    } match_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    full_search_block_matching_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // Shadow copies of the frames and registers.
    logic [7:0] ref_pix [0:16383];
    logic [7:0] cur_pix [0:16383];
    int unsigned cfg_width = 128, cfg_height = 128, cfg_bsize = 8, cfg_range = 7;

    request_t pending_reqs[$];
    match_t   expected_matches[$];
    int       error_count = 0;
    int       idle_cycles = 0;
    int       fired_count = 0;
    int       taken_count = 0;
    bit       long_hold_req = 1'b0;
    bit       long_hold_done = 1'b0;
    int       send_gap = 0;
    int       hold_cnt = 0;

    function automatic int unsigned clip(int unsigned v, int unsigned hi);
        return (v > hi) ? hi : v;
    endfunction

    // Full search over every displacement, first strictly smallest SAD wins.
    function automatic match_t predict_match(int col, int row);
        match_t m;
        int w, h, bs, r, cx, cy, rx, ry, bdx, bdy;
        longint best, sum, a, b;
        w = clip(cfg_width, 128);
        h = clip(cfg_height, 128);
        bs = clip(cfg_bsize, 16);
        r = clip(cfg_range, 15);
        cx = col * bs;
        cy = row * bs;
        m = '{dx: '0, dy: '0, sad: '0, status: 1'b1};
        if (bs == 0 || cx + bs > w || cy + bs > h) begin
            return m;
        end
        best = 64'hFFFF_FFFF;
        bdx = 0;
        bdy = 0;
        for (int dy = -r; dy <= r; dy++) begin
            for (int dx = -r; dx <= r; dx++) begin
                rx = cx + dx;
                ry = cy + dy;
                if (rx < 0 || ry < 0 || rx + bs > w || ry + bs > h) continue;
                sum = 0;
                for (int j = 0; j < bs; j++) begin
                    for (int i = 0; i < bs; i++) begin
                        a = ref_pix[(ry + j) * 128 + rx + i];
                        b = cur_pix[(cy + j) * 128 + cx + i];
                        sum += (a > b) ? a - b : b - a;
                    end
                end
                if (sum < best) begin
                    best = sum;
                    bdx = dx;
                    bdy = dy;
                end
            end
        end
        m.dx = bdx[4:0];
        m.dy = bdy[4:0];
        m.sad = (best > 65535) ? 16'hFFFF : best[15:0];
        m.status = 1'b0;
        return m;
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $time);
        error_count++;
    endtask

    // Input side: record each accepted request and update the shadow state.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            fired_count++;
            if (s_tuser == CMD_LOAD) begin
                if (s_tdata[0]) cur_pix[s_tdata[14:8] * 128 + s_tdata[7:1]] = s_tdata[22:15];
                else ref_pix[s_tdata[14:8] * 128 + s_tdata[7:1]] = s_tdata[22:15];
            end else begin
                expected_matches.insert(expected_matches.size(),
                                        predict_match(s_tdata[29:23], s_tdata[36:30]));
            end
        end
    end

    // Driver: presents pending requests with random gaps.
    always @(negedge aclk) begin
        request_t rq;
        if (aresetn && (!s_tvalid || fired_count != taken_count)) begin
            taken_count = fired_count;
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                rq = pending_reqs.pop_front();
                s_tdata <= {3'b0, rq.brow, rq.bcol, rq.pval, rq.py, rq.px, rq.frame_sel};
                s_tuser <= rq.cmd;
                s_tvalid <= 1'b1;
                case ($urandom_range(0, 19))
                    0: send_gap <= $urandom_range(10, 40);
                    1, 2, 3, 4, 5, 6: send_gap <= $urandom_range(1, 3);
                    default: send_gap <= 0;
                endcase
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge aclk) begin
        if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 29))
                0: begin
                    hold_cnt = $urandom_range(5, 30);
                    m_tready <= 1'b0;
                end
                1, 2, 3, 4, 5, 6, 7: m_tready <= 1'b0;
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge aclk) begin
        match_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_matches.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                e = expected_matches.pop_front();
                if (m_tdata[4:0] !== e.dx) report_mismatch("mv_dx", m_tdata[4:0], e.dx);
                if (m_tdata[9:5] !== e.dy) report_mismatch("mv_dy", m_tdata[9:5], e.dy);
                if (m_tdata[25:10] !== e.sad) report_mismatch("best_sad", m_tdata[25:10], e.sad);
                if (m_tuser !== e.status) report_mismatch("status", m_tuser, e.status);
            end
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 20000) begin
            $display("full_search_block_matching_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_load(logic sel, int x, int y, int v);
        pending_reqs.insert(pending_reqs.size(), '{CMD_LOAD, sel, x[6:0], y[6:0], v[7:0],
                                                    7'($urandom), 7'($urandom)});
    endtask

    task automatic push_search(int col, int row);
        pending_reqs.insert(pending_reqs.size(), '{CMD_SEARCH, 1'($urandom), 7'($urandom),
                                                    7'($urandom), 8'($urandom),
                                                    col[6:0], row[6:0]});
    endtask

    task automatic reg_write(logic [1:0] idx, int unsigned val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_WIDTH:  cfg_width = val & 8'hFF;
            REG_HEIGHT: cfg_height = val & 8'hFF;
            REG_BSIZE:  cfg_bsize = val & 5'h1F;
            default:    cfg_range = val & 4'hF;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_geometry(int w, int h, int bs, int r);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_BSIZE, bs);
        reg_write(REG_RANGE, r);
    endtask

    // Wait until every request is taken and every result has come back.
    task automatic drain_all();
        do @(posedge aclk);
        while (pending_reqs.size() > 0 || s_tvalid || expected_matches.size() > 0);
        repeat (40) @(posedge aclk);
    endtask

    // Load a whole w x h area of both frames.
    task automatic fill_frames(int w, int h);
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                push_load(1'b0, x, y, (x == 0 && y == 0) ? 255 : $urandom_range(0, 255));
                push_load(1'b1, x, y, (x == 1 && y == 0) ? 0 : $urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        int kind;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: corner loads and blocks outside the frame.
        push_load(1'b0, 127, 127, 255);
        push_load(1'b1, 127, 127, 0);
        push_search(16, 0);
        push_search(0, 16);
        push_search(127, 127);
        drain_all();

        // Small frame, widest search range, all blocks searched.
        set_geometry(6, 6, 2, 15);
        fill_frames(6, 6);
        for (int r = 0; r < 3; r++) for (int c = 0; c < 3; c++) push_search(c, r);
        push_search(3, 0);
        drain_all();

        // Smallest frame and range, then zero and oversized block sizes.
        set_geometry(1, 1, 1, 0);
        push_search(0, 0);
        push_search(1, 0);
        drain_all();
        reg_write(REG_BSIZE, 0);
        push_search(0, 0);
        drain_all();
        reg_write(REG_BSIZE, 31);
        push_search(0, 0);
        drain_all();

        // Random traffic; the receiver holds off long at the start.
        set_geometry(6, 6, 3, 7);
        long_hold_req = 1'b1;
        for (int n = 0; n < 200; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                push_load(1'($urandom), $urandom_range(0, 5), $urandom_range(0, 5),
                          $urandom_range(0, 255));
            end else if (kind == 6) begin
                push_load(1'($urandom), $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 255));
            end else if (kind == 9 && $urandom_range(0, 2) == 0) begin
                push_search($urandom_range(0, 127), $urandom_range(0, 127));
            end else begin
                push_search($urandom_range(0, 1), $urandom_range(0, 1));
            end
        end
        drain_all();

        // Largest geometry settings; only blocks outside the frame are searched.
        set_geometry(128, 128, 16, 15);
        push_search(8, 0);
        push_search(0, 8);
        drain_all();

        if (error_count == 0) begin
            $display("full_search_block_matching_top verification clean");
        end else begin
            $display("full_search_block_matching_top verification failed");
        end
        $finish;
    end

endmodule
